### rtl/assert_macros.svh
// Assertion macros used by the scancode decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset.
`define S2A_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define S2A_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define S2A_ASSERT(lbl, prop, msg)
`define S2A_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/s2a_pkg.sv
// Types, key codes and keymap tables for the set-1 scancode decoder.
package s2a_pkg;

  localparam int unsigned CODE_W = 8;
  localparam int unsigned CHAR_W = 7;

  // Set-1 key codes; a release code is the press code with bit 7 set
  localparam logic [CODE_W-1:0] KC_CTRL    = 8'h1D;
  localparam logic [CODE_W-1:0] KC_LSHIFT  = 8'h2A;
  localparam logic [CODE_W-1:0] KC_RSHIFT  = 8'h36;
  localparam logic [CODE_W-1:0] KC_ALT     = 8'h38;
  localparam logic [CODE_W-1:0] KC_CAPS    = 8'h3A;
  localparam logic [CODE_W-1:0] KC_BKSP    = 8'h0E;
  localparam logic [CODE_W-1:0] KC_L       = 8'h26;
  localparam logic [CODE_W-1:0] KC_ENTER   = 8'h1C;
  localparam logic [CODE_W-1:0] REL_OFFSET = 8'h80;
  localparam logic [CODE_W-1:0] TABLE_SIZE = 8'd58;

  localparam logic [CHAR_W-1:0] CASE_FLIP  = 7'h20;
  localparam logic [CHAR_W-1:0] CH_FORMFEED = 7'd12;
  localparam logic [CHAR_W-1:0] CH_NONE    = 7'h00;

  // Modifier state carried from one item to the next
  typedef struct packed {
    logic ctrl_held;
    logic shift_held;
    logic alt_held;
    logic caps_on;
  } s2a_flags_t;

  localparam s2a_flags_t FLAGS_RESET = '{default: 1'b0};

  // Decode outcome for one scancode
  typedef struct packed {
    logic              emit;
    logic [CHAR_W-1:0] ch;
  } s2a_result_t;

  // Unshifted column, padded with zeros beyond the last key
  localparam logic [CHAR_W-1:0] KEYMAP_LO [64] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Shifted column
  localparam logic [CHAR_W-1:0] KEYMAP_HI [64] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

### rtl/s2a_decode.sv
// Combinational decode of one scancode: modifier update and character lookup.
module s2a_decode
  import s2a_pkg::*;
(
  input  logic [CODE_W-1:0] code,
  input  s2a_flags_t        flags,
  output s2a_flags_t        flags_next,
  output s2a_result_t       result
);

  logic              is_mod;
  logic [CHAR_W-1:0] looked_up;
  logic [CHAR_W-1:0] cased;
  logic [CHAR_W-1:0] ch;

  // Modifier and caps codes only touch the flags
  always_comb begin
    flags_next = flags;
    is_mod     = 1'b1;
    unique case (code)
      KC_CTRL:                                     flags_next.ctrl_held  = 1'b1;
      KC_CTRL + REL_OFFSET:                        flags_next.ctrl_held  = 1'b0;
      KC_LSHIFT, KC_RSHIFT:                        flags_next.shift_held = 1'b1;
      KC_LSHIFT + REL_OFFSET, KC_RSHIFT + REL_OFFSET: flags_next.shift_held = 1'b0;
      KC_ALT:                                      flags_next.alt_held   = 1'b1;
      KC_ALT + REL_OFFSET:                         flags_next.alt_held   = 1'b0;
      KC_CAPS:                                     flags_next.caps_on    = ~flags.caps_on;
      KC_CAPS + REL_OFFSET:                        is_mod = 1'b1;
      default:                                     is_mod = 1'b0;
    endcase
  end

  // Table lookup, shifted column while shift is held
  always_comb begin
    if (flags.shift_held) begin
      looked_up = KEYMAP_HI[code[5:0]];
    end else begin
      looked_up = KEYMAP_LO[code[5:0]];
    end
  end

  // Caps lock swaps the case of letters only
  always_comb begin
    cased = looked_up;
    if (flags.caps_on) begin
      if (looked_up >= 7'h61 && looked_up <= 7'h7A) begin
        cased = looked_up - CASE_FLIP;
      end else if (looked_up >= 7'h41 && looked_up <= 7'h5A) begin
        cased = looked_up + CASE_FLIP;
      end
    end
  end

  // Modifier, alt, range and ctrl filters, then the table path
  always_comb begin
    if (is_mod) begin
      ch = CH_NONE;
    end else if (flags.alt_held && code != KC_BKSP) begin
      ch = CH_NONE;
    end else if (code >= TABLE_SIZE) begin
      ch = CH_NONE;
    end else if (flags.ctrl_held && code == KC_L) begin
      ch = CH_FORMFEED;
    end else if (flags.ctrl_held && code != KC_BKSP && code != KC_ENTER) begin
      ch = CH_NONE;
    end else begin
      ch = cased;
    end
  end

  assign result.ch   = ch;
  assign result.emit = (ch != CH_NONE);

endmodule

### rtl/scancode_to_ascii_decoder_top.sv
// Top level of the set-1 scancode to ASCII decoder: input and result registers.
//
// Usage:
//   Scancode bytes enter on the scancode channel (scancode_valid /
//   scancode_ready); characters leave on the ascii channel (ascii_valid /
//   ascii_ready). Modifier, caps and unmapped codes update state or are
//   dropped and give no character.
//   A scancode taken into the input register gives its character, if any,
//   on ascii_char from the result register (one input register, one result register).
//   Throughput: one scancode per cycle while the receiver takes results.
//   The input register drains into the result register in the same cycle
//   as the receiver takes the waiting character, so a back-to-back stream
//   flows without bubbles.
//   Stall: while ascii_ready is low with a character waiting, one further
//   scancode is held in the input register and scancode_ready drops.
//   Reset: synchronous rst clears both registers' valid flags and the
//   ctrl, shift, alt and caps flags; the block is ready in the next cycle.
module scancode_to_ascii_decoder_top
  import s2a_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CODE_W-1:0] scancode,
  input  logic              scancode_valid,
  output logic              scancode_ready,
  output logic [CHAR_W-1:0] ascii_char,
  output logic              ascii_valid,
  input  logic              ascii_ready
);

`include "assert_macros.svh"

  logic              s1_valid;
  logic [CODE_W-1:0] s1_code;
  s2a_flags_t        flags;
  s2a_flags_t        flags_next;
  s2a_result_t       result;
  logic              advance;
  logic              accept;

  // Handshake: the input stage moves on when the result register is empty or being taken
  assign advance        = s1_valid && (!ascii_valid || ascii_ready);
  assign scancode_ready = !s1_valid || advance;
  assign accept         = scancode_valid && scancode_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scancode_ready) begin
      s1_valid <= scancode_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_code <= scancode;
    end
  end

  s2a_decode u_decode (
    .code       (s1_code),
    .flags      (flags),
    .flags_next (flags_next),
    .result     (result)
  );

  // Modifier flags, updated as each item leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= FLAGS_RESET;
    end else if (advance) begin
      flags <= flags_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ascii_valid <= 1'b0;
    end else if (advance) begin
      ascii_valid <= result.emit;
    end else if (ascii_ready) begin
      ascii_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      ascii_char <= result.ch;
    end
  end

  // Checks
  `S2A_ASSERT(a_char_nonzero, ascii_valid |-> (ascii_char != CH_NONE),
              "result register holds a null character")
  `S2A_ASSERT(a_s1_holds, (s1_valid && !advance) |=> (s1_valid && $stable(s1_code)),
              "stalled input stage lost its item")
  `S2A_ASSERT(a_caps_only_on_press, !(advance && s1_code == KC_CAPS) |=> $stable(flags.caps_on),
              "caps flag changed without a caps press")
  `S2A_ASSERT_ALWAYS(a_reset_clears, rst |=> (!s1_valid && !ascii_valid && flags == FLAGS_RESET),
                     "reset did not clear control state")

endmodule

### dv/tb_scancode_to_ascii_decoder_top.sv
// Testbench for the set-1 scancode to ASCII decoder: queued driver, monitor and key predictor.
module tb_scancode_to_ascii_decoder_top
  import s2a_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned DRAIN_EVERY  = 400;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned DRAIN_LIMIT  = 5000;

  localparam logic [CHAR_W-1:0] LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z = 7'h7A;
  localparam logic [CHAR_W-1:0] UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z = 7'h5A;

  // Key positions, unshifted
  localparam logic [CHAR_W-1:0] PLAIN_COL [58] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,  // esc 1..6
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,  // 7..0 - = bs tab
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,  // q..i
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,  // o p [ ] enter ctrl a s
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,  // d..l ;
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,  // ' ` lshift \ z x c v
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,  // b n m , . / rshift kp*
    7'h00, 7'h20                                             // alt space
  };

  // Same positions with shift held
  localparam logic [CHAR_W-1:0] SHIFT_COL [58] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
    7'h00, 7'h20
  };

  // Opening directed sequence
  localparam int unsigned OPENING_LEN = 29;
  localparam logic [CODE_W-1:0] OPENING [OPENING_LEN] = '{
    8'h00, 8'h01, 8'h10, 8'h28, 8'h39,                  // empty entry, esc, q, ', space
    KC_LSHIFT, 8'h28, 8'h1E, KC_LSHIFT | REL_OFFSET,    // shifted quote and letter
    KC_CAPS, 8'h1E, KC_RSHIFT, 8'h1E, 8'h0C,            // caps, caps with shift
    KC_RSHIFT | REL_OFFSET, KC_CAPS | REL_OFFSET,       // caps release is inert
    KC_CAPS, KC_CTRL, KC_L, KC_ENTER, KC_BKSP, 8'h1E,   // ctrl combinations
    KC_CTRL | REL_OFFSET,
    KC_ALT, KC_BKSP, 8'h10, KC_ALT | REL_OFFSET,        // alt combinations
    TABLE_SIZE, 8'hFF                                   // beyond the table
  };

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              hold_for_drain;
  } key_item_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_MASK,
    RX_SLOW
  } rx_mode_t;

  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic [CODE_W-1:0] scancode       = '0;
  logic              scancode_valid = 1'b0;
  logic              scancode_ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              ascii_valid;
  logic              ascii_ready    = 1'b0;

  key_item_t         key_queue [$];
  logic [CHAR_W-1:0] char_queue [$];
  int unsigned       result_backlog = 0;
  int unsigned       fail_count     = 0;
  logic              drain_next     = 1'b0;

  // Predictor's copy of the modifier state
  logic ctrl_down  = 1'b0;
  logic shift_down = 1'b0;
  logic alt_down   = 1'b0;
  logic caps_lock  = 1'b0;

  scancode_to_ascii_decoder_top dut (
    .clk            (clk),
    .rst            (rst),
    .scancode       (scancode),
    .scancode_valid (scancode_valid),
    .scancode_ready (scancode_ready),
    .ascii_char     (ascii_char),
    .ascii_valid    (ascii_valid),
    .ascii_ready    (ascii_ready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Update modifier state and translate one scancode
  task automatic decode_scancode(input logic [CODE_W-1:0] code, output logic emit,
                                 output logic [CHAR_W-1:0] ch);
    ch = CH_NONE;
    if (code == KC_CTRL) begin
      ctrl_down = 1'b1;
    end else if (code == (KC_CTRL | REL_OFFSET)) begin
      ctrl_down = 1'b0;
    end else if (code == KC_LSHIFT || code == KC_RSHIFT) begin
      shift_down = 1'b1;
    end else if (code == (KC_LSHIFT | REL_OFFSET) || code == (KC_RSHIFT | REL_OFFSET)) begin
      shift_down = 1'b0;
    end else if (code == KC_ALT) begin
      alt_down = 1'b1;
    end else if (code == (KC_ALT | REL_OFFSET)) begin
      alt_down = 1'b0;
    end else if (code == KC_CAPS) begin
      caps_lock = ~caps_lock;
    end else if (code == (KC_CAPS | REL_OFFSET)) begin
      ch = CH_NONE;
    end else if (alt_down && code != KC_BKSP) begin
      ch = CH_NONE;
    end else if (code >= TABLE_SIZE) begin
      ch = CH_NONE;
    end else if (ctrl_down && code == KC_L) begin
      ch = CH_FORMFEED;
    end else if (ctrl_down && code != KC_BKSP && code != KC_ENTER) begin
      ch = CH_NONE;
    end else begin
      ch = shift_down ? SHIFT_COL[code[5:0]] : PLAIN_COL[code[5:0]];
      // caps swaps letter case in either column
      if (caps_lock && ((ch >= LOWER_A && ch <= LOWER_Z) || (ch >= UPPER_A && ch <= UPPER_Z)))
        ch = ch ^ CASE_FLIP;
    end
    emit = (ch != CH_NONE);
  endtask

  task automatic push_key(input logic [CODE_W-1:0] code);
    key_item_t item;
    item.code           = code;
    item.hold_for_drain = drain_next;
    drain_next          = 1'b0;
    key_queue.push_back(item);
  endtask

  // Driver: bursts of items separated by random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    key_item_t item;
    if (rst) begin
      scancode_valid <= 1'b0;
    end else if (!scancode_valid || scancode_ready) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        scancode_valid <= 1'b0;
      end else if (key_queue.size() != 0 &&
                   (!key_queue[0].hold_for_drain || (!scancode_valid && result_backlog == 0))) begin
        item = key_queue.pop_front();
        scancode       <= item.code;
        scancode_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        scancode_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall behaviour changes from phase to phase
  rx_mode_t    rx_mode       = RX_FREE;
  int unsigned rx_phase_left = 0;
  logic [7:0]  rx_mask       = 8'hFF;
  logic [2:0]  rx_tick       = '0;

  always @(posedge clk) begin
    if (rst) begin
      ascii_ready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode       <= rx_mode_t'($urandom_range(0, 3));
        rx_mask       <= 8'($urandom_range(1, 255));
        rx_phase_left <= $urandom_range(32, 256);
      end else begin
        rx_phase_left <= rx_phase_left - 1;
      end
      rx_tick <= rx_tick + 1'b1;
      case (rx_mode)
        RX_FREE: ascii_ready <= 1'b1;
        RX_COIN: ascii_ready <= 1'($urandom_range(0, 1));
        RX_MASK: ascii_ready <= rx_mask[rx_tick];
        default: ascii_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: check results first, then predict for the item taken at this edge
  logic [CHAR_W-1:0] want_char;
  logic [CHAR_W-1:0] pred_char;
  logic              pred_emit;

  always @(posedge clk) begin
    if (!rst) begin
      if (ascii_valid && ascii_ready) begin
        if (char_queue.size() == 0) begin
          $error("ascii_char: unexpected result, actual %h", ascii_char);
          fail_count++;
        end else begin
          want_char = char_queue.pop_front();
          if (ascii_char !== want_char) begin
            $error("ascii_char mismatch: expected %h, actual %h", want_char, ascii_char);
            fail_count++;
          end
        end
      end
      if (scancode_valid && scancode_ready) begin
        decode_scancode(scancode, pred_emit, pred_char);
        if (pred_emit)
          char_queue.push_back(pred_char);
      end
    end
    result_backlog <= char_queue.size();
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned drain_at;
    int unsigned reps;
    int unsigned waited;
    logic [CODE_W-1:0] modifier;
    logic [CODE_W-1:0] key;

    for (int i = 0; i < OPENING_LEN; i++)
      push_key(OPENING[i]);

    // mostly typing with balanced modifiers, some noise and stuck keys
    drain_next = 1'b1;
    drain_at   = key_queue.size() + DRAIN_EVERY;
    while (key_queue.size() < OPENING_LEN + RANDOM_ITEMS) begin
      if (key_queue.size() >= drain_at) begin
        drain_next = 1'b1;
        drain_at   = drain_at + DRAIN_EVERY;
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          key = CODE_W'($urandom_range(0, TABLE_SIZE - 1));
          push_key(key);
          if ($urandom_range(0, 1))
            push_key(key | REL_OFFSET);
        end
        11, 12, 13: begin
          case ($urandom_range(0, 3))
            0:       modifier = KC_CTRL;
            1:       modifier = KC_LSHIFT;
            2:       modifier = KC_RSHIFT;
            default: modifier = KC_ALT;
          endcase
          push_key(modifier);
          reps = $urandom_range(1, 5);
          for (int r = 0; r < reps; r++)
            push_key(CODE_W'($urandom_range(0, TABLE_SIZE - 1)));
          if ($urandom_range(0, 6) != 0)
            push_key(modifier | REL_OFFSET);
        end
        14, 15: begin
          push_key(KC_CAPS);
          if ($urandom_range(0, 1))
            push_key(KC_CAPS | REL_OFFSET);
        end
        default: push_key(CODE_W'($urandom_range(0, 255)));
      endcase
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (key_queue.size() != 0 || scancode_valid)
      @(negedge clk);
    waited = 0;
    while (result_backlog != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (char_queue.size() != 0)
      $error("ascii_char: %0d expected results never arrived", char_queue.size());

    if (fail_count == 0 && char_queue.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
